FILE: sv/ineb_pkg.sv
`default_nettype none
package ineb_pkg;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_UNDO = 2'd1;
  localparam logic [1:0] CMD_REDO = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NOP  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HREAD,
    S_HWAIT,
    S_VSCAN,
    S_ESCAN,
    S_CROSS,
    S_CHECK,
    S_EMIT_ST,
    S_EMIT_E
  } state_e;

  typedef logic [9:0]  vidx_t;
  typedef logic [10:0] vcount_t;
  typedef logic [12:0] ecount_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_t;

  typedef struct packed {
    logic       edge_valid;
    vidx_t      edge_from;
    vidx_t      edge_to;
    vcount_t    vertex_count;
    ecount_t    edge_count;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic    cap;
    logic    cur_undo;
    logic    cur_redo;
    logic    hist_rd;
    logic    restore;
    logic    vscan_start;
    logic    escan_start;
    logic    cross_mul;
    logic    cross_set;
    logic    set_zero;
    logic    set_one;
    logic    commit;
    logic    emit_st;
    logic    emit_edge;
    status_e st;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       vc_full;
    logic       vc_zero;
    logic       vc_one;
    logic       undo_ok;
    logic       redo_ok;
    logic       fits;
    logic       vs_busy;
    logic       es_busy;
    logic       out_free;
    logic       k_last;
    logic       n_zero;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/ineb_ctrl.sv
`default_nettype none
module ineb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ineb_pkg::sts_t sts_i,
  output ineb_pkg::ctl_t      ctl_o
);

  ineb_pkg::state_e  state_q, state_d;
  ineb_pkg::status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ineb_pkg::S_IDLE;
      st_q    <= ineb_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      ineb_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ineb_pkg::S_DECODE;
      end
      ineb_pkg::S_DECODE: begin
        priority if (sts_i.cmd == ineb_pkg::CMD_ADD) begin
          if (sts_i.vc_full) begin
            st_d    = ineb_pkg::ST_FULL;
            state_d = ineb_pkg::S_EMIT_ST;
          end else if (sts_i.vc_zero || sts_i.vc_one) begin
            state_d = ineb_pkg::S_CHECK;
          end else begin
            state_d = ineb_pkg::S_VSCAN;
          end
        end else if (sts_i.cmd == ineb_pkg::CMD_UNDO) begin
          st_d    = sts_i.undo_ok ? ineb_pkg::ST_DONE : ineb_pkg::ST_NOP;
          state_d = sts_i.undo_ok ? ineb_pkg::S_HREAD : ineb_pkg::S_EMIT_ST;
        end else if (sts_i.cmd == ineb_pkg::CMD_REDO) begin
          st_d    = sts_i.redo_ok ? ineb_pkg::ST_DONE : ineb_pkg::ST_NOP;
          state_d = sts_i.redo_ok ? ineb_pkg::S_HREAD : ineb_pkg::S_EMIT_ST;
        end else begin
          st_d    = ineb_pkg::ST_DONE;
          state_d = ineb_pkg::S_EMIT_ST;
        end
      end
      ineb_pkg::S_HREAD: state_d = ineb_pkg::S_HWAIT;
      ineb_pkg::S_HWAIT: state_d = ineb_pkg::S_EMIT_ST;
      ineb_pkg::S_VSCAN: begin
        if (!sts_i.vs_busy) state_d = ineb_pkg::S_ESCAN;
      end
      ineb_pkg::S_ESCAN: begin
        if (!sts_i.es_busy) state_d = ineb_pkg::S_CROSS;
      end
      ineb_pkg::S_CROSS: state_d = ineb_pkg::S_CHECK;
      ineb_pkg::S_CHECK: begin
        if (sts_i.fits) begin
          st_d    = ineb_pkg::ST_DONE;
          state_d = sts_i.n_zero ? ineb_pkg::S_EMIT_ST : ineb_pkg::S_EMIT_E;
        end else begin
          st_d    = ineb_pkg::ST_FULL;
          state_d = ineb_pkg::S_EMIT_ST;
        end
      end
      ineb_pkg::S_EMIT_ST: begin
        if (sts_i.out_free) state_d = ineb_pkg::S_IDLE;
      end
      ineb_pkg::S_EMIT_E: begin
        if (sts_i.out_free && sts_i.k_last) state_d = ineb_pkg::S_IDLE;
      end
      default: state_d = ineb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    ctl_o.st   = st_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ineb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.cap  = in_valid_i;
      end
      ineb_pkg::S_DECODE: begin
        priority if (sts_i.cmd == ineb_pkg::CMD_ADD) begin
          if (!sts_i.vc_full) begin
            ctl_o.set_zero    = sts_i.vc_zero;
            ctl_o.set_one     = sts_i.vc_one;
            ctl_o.vscan_start = !sts_i.vc_zero && !sts_i.vc_one;
          end
        end else if (sts_i.cmd == ineb_pkg::CMD_UNDO) begin
          ctl_o.cur_undo = sts_i.undo_ok;
        end else if (sts_i.cmd == ineb_pkg::CMD_REDO) begin
          ctl_o.cur_redo = sts_i.redo_ok;
        end else begin
          ctl_o.cap = 1'b0;
        end
      end
      ineb_pkg::S_HREAD: ctl_o.hist_rd = 1'b1;
      ineb_pkg::S_HWAIT: ctl_o.restore = 1'b1;
      ineb_pkg::S_VSCAN: ctl_o.escan_start = !sts_i.vs_busy;
      ineb_pkg::S_ESCAN: ctl_o.cross_mul = !sts_i.es_busy;
      ineb_pkg::S_CROSS: ctl_o.cross_set = 1'b1;
      ineb_pkg::S_CHECK: ctl_o.commit = sts_i.fits;
      ineb_pkg::S_EMIT_ST: ctl_o.emit_st = sts_i.out_free;
      ineb_pkg::S_EMIT_E: ctl_o.emit_edge = sts_i.out_free;
      default: ctl_o.cap = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/ineb_datapath.sv
`default_nettype none
module ineb_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int COORD_BITS   = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ineb_pkg::in_t  in_i,
  input  wire ineb_pkg::ctl_t ctl_i,
  output ineb_pkg::sts_t      sts_o,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output ineb_pkg::out_t      out_o
);

  localparam int VIDX = $clog2(MAX_VERTICES);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);
  localparam int EIDX = $clog2(MAX_EDGES);
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int HW   = $clog2(MAX_VERTICES + 2);
  localparam int HA   = $clog2(MAX_VERTICES + 1);
  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int SW   = 2 * DW;
  localparam int DSW  = SW + 2;
  localparam int CYW  = SW + 1;

  // captured command
  logic [1:0]          cmd_q;
  logic signed [C-1:0] x_q, y_q, z_q;
  logic [31:0]         ix, iy, iz;

  // counts and history
  logic [VCW-1:0] vc_q;
  logic [ECW-1:0] ec_q;
  logic [HW-1:0]  cur_q, len_q, len1;
  logic [ECW-1:0] hist_mem [MAX_VERTICES+1];
  logic [ECW-1:0] hrd_q;
  logic           hz_q;

  // stores
  logic [3*C-1:0]    vmem [MAX_VERTICES];
  logic [2*VIDX-1:0] emem [MAX_EDGES];

  // vertex scan pipeline
  logic                 vrun_q, p1_v_q, p2_v_q, p3_v_q;
  logic [VCW-1:0]       vi_q;
  logic [3*C-1:0]       vrd_q;
  logic [VIDX-1:0]      p1_i_q, p2_i_q, p3_i_q;
  logic signed [C-1:0]  rx, ry, rz;
  logic signed [DW-1:0] dx_c, dy_c, dz_c;
  logic signed [SW-1:0] sqx_c, sqy_c, sqz_c;
  logic [SW-1:0]        sqx_q, sqy_q, sqz_q;
  logic signed [DW-1:0] p2_dx_q, p2_dz_q, p3_dx_q, p3_dz_q;
  logic [DSW-1:0]       p3_d_q, d1_q, d2_q;
  logic [VIDX-1:0]      i1_q, i2_q;
  logic signed [DW-1:0] a1x_q, a1z_q, a2x_q, a2z_q;

  // edge scan
  logic              erun_q, pe_v_q, present_q;
  logic [ECW-1:0]    ei_q;
  logic [2*VIDX-1:0] erd_q;

  // orientation and new edges
  logic signed [SW-1:0]  m1_q, m2_q;
  logic signed [CYW-1:0] cy;
  logic [VIDX-1:0]       nf_q [3];
  logic [VIDX-1:0]       nt_q [3];
  logic [VIDX-1:0]       vcix;
  logic [1:0]            n_q, k_q;
  logic [ECW-1:0]        ebase_q, ewa;

  logic           ov_q;
  ineb_pkg::out_t out_q;

  assign ix   = 32'(in_i.pos_x[15:0]);
  assign iy   = 32'(in_i.pos_y[15:0]);
  assign iz   = 32'(in_i.pos_z[15:0]);
  assign len1 = (cur_q < len_q) ? cur_q + HW'(1) : len_q;
  assign vcix = vc_q[VIDX-1:0];
  assign ewa  = ebase_q + ECW'(k_q);

  assign rx    = vrd_q[3*C-1:2*C];
  assign ry    = vrd_q[2*C-1:C];
  assign rz    = vrd_q[C-1:0];
  assign dx_c  = DW'(rx) - DW'(x_q);
  assign dy_c  = DW'(ry) - DW'(y_q);
  assign dz_c  = DW'(rz) - DW'(z_q);
  assign sqx_c = dx_c * dx_c;
  assign sqy_c = dy_c * dy_c;
  assign sqz_c = dz_c * dz_c;
  assign cy    = CYW'(m1_q) - CYW'(m2_q);

  always_comb begin
    sts_o          = '0;
    sts_o.cmd      = cmd_q;
    sts_o.vc_full  = 32'(vc_q) >= 32'(MAX_VERTICES);
    sts_o.vc_zero  = vc_q == '0;
    sts_o.vc_one   = vc_q == VCW'(1);
    sts_o.undo_ok  = (cur_q >= len_q) ? (len_q >= HW'(2)) : (cur_q != '0);
    sts_o.redo_ok  = !((cur_q >= len_q) || (cur_q + HW'(1) == len_q));
    sts_o.fits     = 32'(ec_q) + 32'(n_q) <= 32'(MAX_EDGES);
    sts_o.vs_busy  = vrun_q || p1_v_q || p2_v_q || p3_v_q;
    sts_o.es_busy  = erun_q || pe_v_q;
    sts_o.out_free = !ov_q || out_ready_i;
    sts_o.k_last   = k_q == n_q - 2'd1;
    sts_o.n_zero   = n_q == 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q <= in_i.cmd;
      x_q   <= ix[C-1:0];
      y_q   <= iy[C-1:0];
      z_q   <= iz[C-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= '0;
      ec_q  <= '0;
      len_q <= HW'(1);
      cur_q <= HW'(1);
    end else begin
      if (ctl_i.cur_undo) begin
        cur_q <= (cur_q >= len_q) ? len_q - HW'(2) : cur_q - HW'(1);
      end
      if (ctl_i.cur_redo) cur_q <= cur_q + HW'(1);
      if (ctl_i.restore) begin
        vc_q <= VCW'(cur_q);
        ec_q <= hz_q ? '0 : hrd_q;
      end
      if (ctl_i.commit) begin
        vc_q <= vc_q + VCW'(1);
        ec_q <= ec_q + ECW'(n_q);
        if (32'(len1) <= 32'(MAX_VERTICES)) begin
          len_q <= len1 + HW'(1);
          cur_q <= len1 + HW'(1);
        end else begin
          len_q <= len1;
          cur_q <= len1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && 32'(len1) <= 32'(MAX_VERTICES)) begin
      hist_mem[len1[HA-1:0]] <= ec_q + ECW'(n_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hist_rd) begin
      hrd_q <= hist_mem[cur_q[HA-1:0]];
      hz_q  <= cur_q == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) vmem[vcix] <= {x_q, y_q, z_q};
  end

  always_ff @(posedge clk_i) begin
    if (vrun_q) vrd_q <= vmem[vi_q[VIDX-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_edge) emem[ewa[EIDX-1:0]] <= {nf_q[k_q], nt_q[k_q]};
  end

  always_ff @(posedge clk_i) begin
    if (erun_q) erd_q <= emem[ei_q[EIDX-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrun_q <= 1'b0;
      vi_q   <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      erun_q <= 1'b0;
      ei_q   <= '0;
      pe_v_q <= 1'b0;
    end else begin
      p1_v_q <= vrun_q;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      pe_v_q <= erun_q;
      if (ctl_i.vscan_start) begin
        vrun_q <= 1'b1;
        vi_q   <= '0;
      end else if (vrun_q) begin
        vi_q <= vi_q + VCW'(1);
        if (vi_q + VCW'(1) == vc_q) vrun_q <= 1'b0;
      end
      if (ctl_i.escan_start) begin
        erun_q <= ec_q != '0;
        ei_q   <= '0;
      end else if (erun_q) begin
        ei_q <= ei_q + ECW'(1);
        if (ei_q + ECW'(1) == ec_q) erun_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_i_q  <= vi_q[VIDX-1:0];
    p2_i_q  <= p1_i_q;
    p2_dx_q <= dx_c;
    p2_dz_q <= dz_c;
    sqx_q   <= sqx_c;
    sqy_q   <= sqy_c;
    sqz_q   <= sqz_c;
    p3_i_q  <= p2_i_q;
    p3_dx_q <= p2_dx_q;
    p3_dz_q <= p2_dz_q;
    p3_d_q  <= DSW'(sqx_q) + DSW'(sqy_q) + DSW'(sqz_q);
    if (p3_v_q) begin
      priority if (p3_i_q == VIDX'(0)) begin
        d1_q <= p3_d_q; i1_q <= p3_i_q; a1x_q <= p3_dx_q; a1z_q <= p3_dz_q;
      end else if (p3_i_q == VIDX'(1)) begin
        d2_q <= p3_d_q; i2_q <= p3_i_q; a2x_q <= p3_dx_q; a2z_q <= p3_dz_q;
      end else if (p3_d_q < d1_q) begin
        if (d1_q < d2_q) begin
          d2_q <= p3_d_q; i2_q <= p3_i_q; a2x_q <= p3_dx_q; a2z_q <= p3_dz_q;
        end else begin
          d1_q <= p3_d_q; i1_q <= p3_i_q; a1x_q <= p3_dx_q; a1z_q <= p3_dz_q;
        end
      end else if (p3_d_q < d2_q) begin
        d2_q <= p3_d_q; i2_q <= p3_i_q; a2x_q <= p3_dx_q; a2z_q <= p3_dz_q;
      end
    end
    if (ctl_i.escan_start) begin
      present_q <= 1'b0;
    end else if (pe_v_q && (erd_q == {i1_q, i2_q} || erd_q == {i2_q, i1_q})) begin
      present_q <= 1'b1;
    end
    if (ctl_i.cross_mul) begin
      m1_q <= a1z_q * a2x_q;
      m2_q <= a1x_q * a2z_q;
    end
    if (ctl_i.set_zero) n_q <= 2'd0;
    if (ctl_i.set_one) begin
      nf_q[0] <= VIDX'(0);
      nt_q[0] <= VIDX'(1);
      n_q     <= 2'd1;
    end
    if (ctl_i.cross_set) begin
      if (cy[CYW-1]) begin
        nf_q[0] <= i1_q; nt_q[0] <= vcix;
        nf_q[1] <= vcix; nt_q[1] <= i2_q;
      end else begin
        nf_q[0] <= vcix; nt_q[0] <= i1_q;
        nf_q[1] <= i2_q; nt_q[1] <= vcix;
      end
      nf_q[2] <= i1_q;
      nt_q[2] <= i2_q;
      n_q     <= present_q ? 2'd2 : 2'd3;
    end
    if (ctl_i.commit) begin
      ebase_q <= ec_q;
      k_q     <= 2'd0;
    end else if (ctl_i.emit_edge) begin
      k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctl_i.emit_st || ctl_i.emit_edge) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_st) begin
      out_q.edge_valid   <= 1'b0;
      out_q.edge_from    <= '0;
      out_q.edge_to      <= '0;
      out_q.vertex_count <= ineb_pkg::vcount_t'(vc_q);
      out_q.edge_count   <= ineb_pkg::ecount_t'(ec_q);
      out_q.status       <= ctl_i.st;
      out_q.last         <= 1'b1;
    end else if (ctl_i.emit_edge) begin
      out_q.edge_valid   <= 1'b1;
      out_q.edge_from    <= ineb_pkg::vidx_t'(nf_q[k_q]);
      out_q.edge_to      <= ineb_pkg::vidx_t'(nt_q[k_q]);
      out_q.vertex_count <= ineb_pkg::vcount_t'(vc_q);
      out_q.edge_count   <= ineb_pkg::ecount_t'(ec_q);
      out_q.status       <= ineb_pkg::ST_DONE;
      out_q.last         <= k_q == n_q - 2'd1;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

FILE: sv/incremental_nav_edge_builder.sv
`default_nettype none
// Builds a navigation graph one point at a time, with undo and redo of whole
// adds. An add to a graph of two or more points scans every stored point
// through a four-stage distance pipe, then every stored edge, one entry per
// cycle from each store, and then emits its new edges; undo and redo read the
// edge count back from the history memory and restore both counts. An add
// refused for a full vertex store, an undo or redo with nothing to do and an
// undefined command go from decode straight to the status output.
// One transaction is processed at a time; the next one is accepted while the
// last result still waits at the output register.
module incremental_nav_edge_builder #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int COORD_BITS   = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ineb_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ineb_pkg::out_t      out_o
);

  ineb_pkg::ctl_t ctl;
  ineb_pkg::sts_t sts;

  ineb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ineb_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  a_status_no_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ineb_pkg::ST_DONE |-> !out_o.edge_valid)
    else $error("edge reported with non-done status");

  a_edge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.edge_valid |-> out_o.edge_from != out_o.edge_to)
    else $error("self loop edge");

  a_edge_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_o.edge_count) <= 32'(MAX_EDGES))
    else $error("edge count beyond store");

endmodule
`default_nettype wire
